### rtl/core/energy_accumulator_with_history_unit_defines.svh
// Assertion macros shared by the energy accumulator RTL.
`ifndef ENERGY_ACCUMULATOR_WITH_HISTORY_UNIT_DEFINES_SVH
`define ENERGY_ACCUMULATOR_WITH_HISTORY_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define EAHU_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("energy accumulator assertion failed");
`define EAHU_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("energy accumulator assertion failed");
`else
`define EAHU_ASSERT(label, clk, rst, prop)
`define EAHU_ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

### rtl/core/eahu_pkg.sv
package eahu_pkg;

   localparam int DAY_SLOTS = 7;
   localparam int DAY_IDX_W = (DAY_SLOTS > 1) ? $clog2(DAY_SLOTS) : 1;
   localparam int HDAY_W    = 3;
   localparam int DAY_SUM_W = ((DAY_IDX_W > HDAY_W) ? DAY_IDX_W : HDAY_W) + 1;

   localparam int ENERGY_W  = 63;
   localparam int USAGE_W   = 64;
   localparam int POWER_W   = 23;
   localparam int MAG_W     = POWER_W - 1;
   localparam int TIME_W    = 32;
   localparam int PROD_W    = MAG_W + TIME_W;

   localparam logic [ENERGY_W-1:0] ENERGY_MAX = '1;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 40;

   localparam logic [CSR_IDX_W-1:0] CSR_MIN_POWER     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_STEP      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DAY_LENGTH    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SAVE_INTERVAL = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SAVE_DELTA    = 3'd4;

   localparam logic [15:0] MIN_POWER_RESET     = 16'd100;
   localparam logic [19:0] MIN_STEP_RESET      = 20'd1000;
   localparam logic [31:0] DAY_LENGTH_RESET    = 32'd86400000;
   localparam logic [31:0] SAVE_INTERVAL_RESET = 32'd60000;
   localparam logic [39:0] SAVE_DELTA_RESET    = 40'd1800000000;

   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_CLEAR  = 1'b1;

   localparam logic [7:0] YEAR_UNSET    = 8'd0;
   localparam logic [7:0] YEAR_MIN_CAL  = 8'd100;

endpackage

### rtl/core/eahu_ram.sv
module eahu_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 7,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/energy_accumulator_with_history_unit.sv
// Each accepted request word yields exactly one response word. A word passes through
// three working stages (decide and multiply, saturating add, history update and
// read-back) and then waits in the output register. The next word leaves the input
// register only once the previous one has written back all of its state, so a new
// word enters the working stages only after the last one has left them; an input
// register and the output register keep the request side open while a response
// waits. The daily history lives in a small RAM used as a ring with one valid bit
// per entry, so reset and clear words take effect at once and no clearing pass is
// needed.
`include "energy_accumulator_with_history_unit_defines.svh"

module energy_accumulator_with_history_unit
   import eahu_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,

   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_kind,
   input  logic [TIME_W-1:0]           req_time_ms,
   input  logic signed [POWER_W-1:0]   req_power_mw,
   input  logic                        req_meter_ready,
   input  logic                        req_calendar_valid,
   input  logic [7:0]                  req_year,
   input  logic [3:0]                  req_month,
   input  logic [HDAY_W-1:0]           req_history_day,

   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [ENERGY_W-1:0]         rsp_total_energy,
   output logic signed [USAGE_W-1:0]   rsp_month_so_far,
   output logic signed [USAGE_W-1:0]   rsp_last_month,
   output logic signed [USAGE_W-1:0]   rsp_history_value,
   output logic                        rsp_day_rolled,
   output logic signed [USAGE_W-1:0]   rsp_day_used,
   output logic                        rsp_month_rolled,
   output logic signed [USAGE_W-1:0]   rsp_month_total,
   output logic                        rsp_save_total,
   output logic                        rsp_save_daily,
   output logic                        rsp_save_monthly,

   input  logic                        csr_write_en,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]       csr_wdata
);

   typedef struct packed {
      logic               kind;
      logic [TIME_W-1:0]  time_ms;
      logic [POWER_W-1:0] power_mw;
      logic               meter_ready;
      logic               calendar_valid;
      logic [7:0]         year;
      logic [3:0]         month;
      logic [HDAY_W-1:0]  history_day;
   } req_word_type;

   typedef struct packed {
      logic               clear;
      logic               do_add;
      logic [PROD_W-1:0]  product;
      logic               day_roll;
      logic               month_roll;
      logic               save_chk;
      logic [HDAY_W-1:0]  hday;
      logic               hday_ok;
   } add_word_type;

   typedef struct packed {
      logic               clear;
      logic               day_roll;
      logic               month_roll;
      logic               save_chk;
      logic [HDAY_W-1:0]  hday;
      logic               hday_ok;
   } hist_word_type;

   typedef struct packed {
      logic [ENERGY_W-1:0] total;
      logic [USAGE_W-1:0]  month_so_far;
      logic [USAGE_W-1:0]  last_month;
      logic                day_rolled;
      logic [USAGE_W-1:0]  day_used;
      logic                month_rolled;
      logic [USAGE_W-1:0]  month_total;
      logic                save_total;
      logic                save_daily;
      logic                save_monthly;
      logic                hist_ok;
      logic                hist_fwd;
      logic [USAGE_W-1:0]  fwd_data;
   } rsp_word_type;

   // Configuration.
   logic [15:0]           min_power_ff;
   logic [19:0]           min_step_ff;
   logic [31:0]           day_length_ff;
   logic [31:0]           save_interval_ff;
   logic [39:0]           save_delta_ff;

   // Architectural state.
   logic [ENERGY_W-1:0]   total_ff;
   logic [TIME_W-1:0]     step_time_ff;
   logic                  step_started_ff;
   logic [ENERGY_W-1:0]   day_start_energy_ff;
   logic [TIME_W-1:0]     day_start_time_ff;
   logic [ENERGY_W-1:0]   month_start_energy_ff;
   logic [7:0]            month_start_year_ff;
   logic [3:0]            month_start_month_ff;
   logic [USAGE_W-1:0]    last_month_ff;
   logic [ENERGY_W-1:0]   saved_energy_ff;
   logic [TIME_W-1:0]     save_time_ff;
   logic [DAY_IDX_W-1:0]  head_ff;
   logic [DAY_SLOTS-1:0]  day_valid_ff;

   // Pipeline.
   logic                  s1_valid_ff;
   req_word_type          s1_ff;
   logic                  s2_valid_ff;
   add_word_type          s2_ff;
   add_word_type          s2_in;
   logic                  s3_valid_ff;
   hist_word_type         s3_ff;
   hist_word_type         s3_in;
   logic                  s4_valid_ff;
   rsp_word_type          s4_ff;
   rsp_word_type          s4_in;

   logic                  s1_go;
   logic                  s2_go;
   logic                  s3_go;

   // Decide stage.
   logic                  is_clear;
   logic                  is_sample;
   logic [MAG_W-1:0]      power_mag;
   logic                  above;
   logic [TIME_W-1:0]     step_dt;
   logic                  step_due;
   logic                  do_mark;
   logic [TIME_W-1:0]     day_dt;
   logic [TIME_W-1:0]     save_dt;

   // Add stage.
   logic [USAGE_W-1:0]    add_sum;
   logic [ENERGY_W-1:0]   total_in;

   // History stage.
   logic [USAGE_W-1:0]    total_ext;
   logic [USAGE_W-1:0]    day_diff;
   logic [USAGE_W-1:0]    month_diff;
   logic [USAGE_W-1:0]    saved_hi;
   logic [USAGE_W-1:0]    total_hi;
   logic                  save_hit;
   logic [DAY_IDX_W-1:0]  head_inc;
   logic [DAY_IDX_W-1:0]  head_in;
   logic [DAY_SUM_W-1:0]  rd_sum;
   logic [DAY_IDX_W-1:0]  rd_addr;
   logic                  rd_fwd;
   logic                  rd_hit;
   logic [USAGE_W-1:0]    ram_rd_data;

   assign s3_go     = s3_valid_ff && (!s4_valid_ff || rsp_ready);
   assign s2_go     = s2_valid_ff && (!s3_valid_ff || s3_go);
   assign s1_go     = s1_valid_ff && !s2_valid_ff && !s3_valid_ff;
   assign req_ready = !s1_valid_ff || s1_go;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_power_ff     <= MIN_POWER_RESET;
         min_step_ff      <= MIN_STEP_RESET;
         day_length_ff    <= DAY_LENGTH_RESET;
         save_interval_ff <= SAVE_INTERVAL_RESET;
         save_delta_ff    <= SAVE_DELTA_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_MIN_POWER:     min_power_ff     <= csr_wdata[15:0];
            CSR_MIN_STEP:      min_step_ff      <= csr_wdata[19:0];
            CSR_DAY_LENGTH:    day_length_ff    <= csr_wdata[31:0];
            CSR_SAVE_INTERVAL: save_interval_ff <= csr_wdata[31:0];
            CSR_SAVE_DELTA:    save_delta_ff    <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Decide stage: timing checks, threshold and the product for this step.
   always_comb begin
      is_clear  = s1_ff.kind == KIND_CLEAR;
      is_sample = (s1_ff.kind == KIND_SAMPLE) && s1_ff.meter_ready;
      power_mag = s1_ff.power_mw[MAG_W-1:0];
      above     = !s1_ff.power_mw[POWER_W-1] && (power_mag > {6'd0, min_power_ff});
      step_dt   = s1_ff.time_ms - step_time_ff;
      step_due  = step_dt >= {12'd0, min_step_ff};
      do_mark   = is_sample && !(above && step_started_ff && !step_due);
      day_dt    = s1_ff.time_ms - day_start_time_ff;
      save_dt   = s1_ff.time_ms - save_time_ff;

      s2_in.clear      = is_clear;
      s2_in.do_add     = is_sample && above && step_started_ff && step_due;
      s2_in.product    = PROD_W'(power_mag) * PROD_W'(step_dt);
      s2_in.day_roll   = is_sample && (day_dt >= day_length_ff);
      s2_in.month_roll = is_sample && s1_ff.calendar_valid && (s1_ff.year >= YEAR_MIN_CAL) &&
                         ((month_start_year_ff == YEAR_UNSET) ||
                          (s1_ff.month != month_start_month_ff) ||
                          (s1_ff.year != month_start_year_ff));
      s2_in.save_chk   = is_sample && (save_dt > save_interval_ff);
      s2_in.hday       = s1_ff.history_day;
      s2_in.hday_ok    = 32'(s1_ff.history_day) < 32'(DAY_SLOTS);
   end

   // Add stage: the total cannot pass the 63-bit ceiling, it clips there.
   always_comb begin
      add_sum = {1'b0, total_ff} + {{(USAGE_W - PROD_W){1'b0}}, s2_ff.product};
      if (s2_ff.clear) begin
         total_in = '0;
      end else if (s2_ff.do_add) begin
         total_in = add_sum[USAGE_W-1] ? ENERGY_MAX : add_sum[ENERGY_W-1:0];
      end else begin
         total_in = total_ff;
      end
      s3_in.clear      = s2_ff.clear;
      s3_in.day_roll   = s2_ff.day_roll;
      s3_in.month_roll = s2_ff.month_roll;
      s3_in.save_chk   = s2_ff.save_chk;
      s3_in.hday       = s2_ff.hday;
      s3_in.hday_ok    = s2_ff.hday_ok;
   end

   // History stage: the ring head points at the oldest day entry.
   always_comb begin
      total_ext  = {1'b0, total_ff};
      day_diff   = total_ext - {1'b0, day_start_energy_ff};
      month_diff = total_ext - {1'b0, month_start_energy_ff};
      saved_hi   = {1'b0, saved_energy_ff} + {24'd0, save_delta_ff};
      total_hi   = total_ext + {24'd0, save_delta_ff};
      save_hit   = s3_ff.save_chk &&
                   ((total_ext > saved_hi) || ({1'b0, saved_energy_ff} > total_hi));

      head_inc = (head_ff == DAY_IDX_W'(DAY_SLOTS - 1)) ? '0 : head_ff + 1'b1;
      head_in  = s3_ff.day_roll ? head_inc : head_ff;
      rd_sum   = DAY_SUM_W'(head_in) + DAY_SUM_W'(s3_ff.hday);
      if (rd_sum >= DAY_SUM_W'(DAY_SLOTS)) begin
         rd_addr = DAY_IDX_W'(rd_sum - DAY_SUM_W'(DAY_SLOTS));
      end else begin
         rd_addr = DAY_IDX_W'(rd_sum);
      end
      rd_fwd = s3_ff.day_roll && (rd_addr == head_ff);
      rd_hit = !s3_ff.clear && (rd_fwd || day_valid_ff[rd_addr]);

      s4_in.total        = total_ff;
      s4_in.month_so_far = (s3_ff.clear || s3_ff.month_roll) ? '0 : month_diff;
      if (s3_ff.clear) begin
         s4_in.last_month = '0;
      end else if (s3_ff.month_roll) begin
         s4_in.last_month = month_diff;
      end else begin
         s4_in.last_month = last_month_ff;
      end
      s4_in.day_rolled   = s3_ff.day_roll;
      s4_in.day_used     = s3_ff.day_roll ? day_diff : '0;
      s4_in.month_rolled = s3_ff.month_roll;
      s4_in.month_total  = s3_ff.month_roll ? month_diff : '0;
      s4_in.save_total   = s3_ff.clear || save_hit;
      s4_in.save_daily   = s3_ff.clear || s3_ff.day_roll;
      s4_in.save_monthly = s3_ff.clear || s3_ff.month_roll;
      s4_in.hist_ok      = s3_ff.hday_ok && rd_hit;
      s4_in.hist_fwd     = rd_fwd;
      s4_in.fwd_data     = day_diff;
   end

   eahu_ram #(
      .WIDTH (USAGE_W),
      .DEPTH (DAY_SLOTS)
   ) u_day_ram (
      .clock   (clock),
      .wr_en   (s3_go && s3_ff.day_roll),
      .wr_addr (head_ff),
      .wr_data (day_diff),
      .rd_en   (s3_go),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (s1_go || s2_go) begin
            s2_valid_ff <= s1_go;
         end
         if (s2_go || s3_go) begin
            s3_valid_ff <= s2_go;
         end
         if (s3_go || rsp_ready) begin
            s4_valid_ff <= s3_go;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_ff.kind           <= req_kind;
         s1_ff.time_ms        <= req_time_ms;
         s1_ff.power_mw       <= req_power_mw;
         s1_ff.meter_ready    <= req_meter_ready;
         s1_ff.calendar_valid <= req_calendar_valid;
         s1_ff.year           <= req_year;
         s1_ff.month          <= req_month;
         s1_ff.history_day    <= req_history_day;
      end
      if (s1_go) begin
         s2_ff <= s2_in;
      end
      if (s2_go) begin
         s3_ff <= s3_in;
      end
      if (s3_go) begin
         s4_ff <= s4_in;
      end
   end

   // Time marks commit as the word leaves the decide stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_time_ff         <= '0;
         step_started_ff      <= 1'b0;
         day_start_time_ff    <= '0;
         month_start_year_ff  <= YEAR_UNSET;
         month_start_month_ff <= '0;
         save_time_ff         <= '0;
      end else if (s1_go) begin
         if (is_clear) begin
            step_time_ff         <= '0;
            step_started_ff      <= 1'b0;
            month_start_year_ff  <= YEAR_UNSET;
            month_start_month_ff <= '0;
         end else begin
            if (do_mark) begin
               step_time_ff    <= s1_ff.time_ms;
               step_started_ff <= 1'b1;
            end
            if (s2_in.month_roll) begin
               month_start_year_ff  <= s1_ff.year;
               month_start_month_ff <= s1_ff.month;
            end
         end
         if (s2_in.day_roll) begin
            day_start_time_ff <= s1_ff.time_ms;
         end
         if (s2_in.save_chk) begin
            save_time_ff <= s1_ff.time_ms;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
      end else if (s2_go) begin
         total_ff <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         day_start_energy_ff   <= '0;
         month_start_energy_ff <= '0;
         last_month_ff         <= '0;
         saved_energy_ff       <= '0;
         head_ff               <= '0;
         day_valid_ff          <= '0;
      end else if (s3_go) begin
         last_month_ff <= s4_in.last_month;
         if (s3_ff.clear) begin
            month_start_energy_ff <= '0;
            saved_energy_ff       <= '0;
            day_valid_ff          <= '0;
         end else begin
            if (s3_ff.day_roll) begin
               day_start_energy_ff   <= total_ff;
               day_valid_ff[head_ff] <= 1'b1;
               head_ff               <= head_inc;
            end
            if (s3_ff.month_roll) begin
               month_start_energy_ff <= total_ff;
            end
            if (save_hit) begin
               saved_energy_ff <= total_ff;
            end
         end
      end
   end

   assign rsp_valid         = s4_valid_ff;
   assign rsp_total_energy  = s4_ff.total;
   assign rsp_month_so_far  = s4_ff.month_so_far;
   assign rsp_last_month    = s4_ff.last_month;
   assign rsp_history_value = !s4_ff.hist_ok ? '0 :
                              (s4_ff.hist_fwd ? s4_ff.fwd_data : ram_rd_data);
   assign rsp_day_rolled    = s4_ff.day_rolled;
   assign rsp_day_used      = s4_ff.day_used;
   assign rsp_month_rolled  = s4_ff.month_rolled;
   assign rsp_month_total   = s4_ff.month_total;
   assign rsp_save_total    = s4_ff.save_total;
   assign rsp_save_daily    = s4_ff.save_daily;
   assign rsp_save_monthly  = s4_ff.save_monthly;

   `EAHU_ASSERT_NEVER(a_one_word_in_flight, clock, reset, s2_valid_ff && s3_valid_ff)
   `EAHU_ASSERT(a_clear_zeroes_total, clock, reset, s2_go && s2_ff.clear |=> total_ff == '0)
   `EAHU_ASSERT(a_day_roll_saves, clock, reset, rsp_valid && rsp_day_rolled |-> rsp_save_daily)
   `EAHU_ASSERT(a_month_roll_saves, clock, reset,
                rsp_valid && rsp_month_rolled |-> rsp_save_monthly)

endmodule
